FILE: rtl/core/chki_pkg.sv
`default_nettype none
package chki_pkg;
	localparam int MAX_BUCKETS = 4096;
	localparam int POOL_NODES = 4096;
	localparam int RECORD_BITS = 64;
	localparam int BKT_AW = $clog2(MAX_BUCKETS);
	localparam int NODE_AW = $clog2(POOL_NODES);
	localparam int CNT_W = $clog2(POOL_NODES + 1);
	localparam int BC_W = 13;
	localparam int KEY_W = 21;
	localparam int REC_W = 64;
	localparam int ST_W = 2;
	localparam logic [31:0] HASH_MUL = 32'h045d9f3b;
	localparam int HASH_SHIFT = 16;
	localparam logic [BC_W-1:0] MIN_BUCKETS = BC_W'(64);
	localparam logic [BC_W-1:0] BC_RESET = BC_W'(64);
	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_MISS = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL = 2'd2;
	localparam logic MODE_FIND = 1'b0;
	localparam logic MODE_INSERT = 1'b1;
	localparam int HEAD_W = NODE_AW + 1;
	localparam int NODE_W = KEY_W + RECORD_BITS + NODE_AW + 1;
	localparam int REG_NBUCKETS = 0;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [RECORD_BITS-1:0] rec;
		logic [NODE_AW-1:0] link;
		logic has_next;
	} node_t;
endpackage
`default_nettype wire

FILE: rtl/core/chki_if.sv
`default_nettype none
interface chki_in_if;
	logic valid;
	logic ready;
	logic mode;
	logic [20:0] code_point;
	logic [63:0] record;
	modport source(output valid, mode, code_point, record, input ready);
	modport sink(input valid, mode, code_point, record, output ready);
endinterface

interface chki_out_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [63:0] found_record;
	modport source(output valid, status, found_record, input ready);
	modport sink(input valid, status, found_record, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/chki_ram.sv
`default_nettype none
module chki_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/core/chained_hash_key_index.sv
`default_nettype none
// Chained hash index of glyph records. One word in, one word out. The key is hashed
// with two multiply rounds (one 32x32 multiply per cycle, registered), then reduced
// modulo the bucket count (the register clamped to 64..MAX_BUCKETS) by a restoring
// divider one quotient bit a cycle. The bucket head is then read; an insert writes
// its node and the new head unless the pool is full, and a find walks the chain,
// each node costing one read of the node memory. Items are handled one at a time.
// After reset a clearing pass writes every bucket head, one per cycle, during which
// no word is accepted.
module chained_hash_key_index (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	chki_in_if.sink in_ch,
	chki_out_if.source out_ch
);
	import chki_pkg::*;

	localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_M1 = 4'd2, S_M2 = 4'd3,
		S_DIV = 4'd4, S_HRD = 4'd5, S_HWT = 4'd6, S_INS = 4'd7, S_NRD = 4'd8,
		S_NWT = 4'd9, S_OUT = 4'd10;

	logic [3:0] state_q;
	logic [BC_W-1:0] bc_q;
	logic [BKT_AW-1:0] clr_q;
	logic mode_q;
	logic [KEY_W-1:0] key_q;
	logic [RECORD_BITS-1:0] rec_q;
	logic [31:0] h_q;
	logic [31:0] rem_q;
	logic [BC_W-1:0] div_q;
	logic [5:0] dcnt_q;
	logic [CNT_W-1:0] used_q;
	logic [NODE_AW-1:0] cur_q;
	logic [NODE_AW:0] steps_q;
	logic [ST_W-1:0] st_q;
	logic [REC_W-1:0] fr_q;

	logic h_we;
	logic [BKT_AW-1:0] h_waddr, h_raddr;
	logic [HEAD_W-1:0] h_wdata, h_rdata;
	logic n_we;
	logic [NODE_AW-1:0] n_raddr;
	node_t n_wdata, n_rdata;

	chki_ram #(.WIDTH(HEAD_W), .DEPTH(MAX_BUCKETS)) u_head (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata));
	chki_ram #(.WIDTH(NODE_W), .DEPTH(POOL_NODES)) u_node (
		.clk(clk), .we(n_we), .waddr(used_q[NODE_AW-1:0]), .wdata(n_wdata),
		.raddr(n_raddr), .rdata(n_rdata));

	logic [31:0] mixed, prod;
	logic [32:0] trial;
	logic [BC_W-1:0] bc_eff;
	assign mixed = (h_q >> HASH_SHIFT) ^ h_q;
	assign prod = mixed * HASH_MUL;
	assign bc_eff = (bc_q < MIN_BUCKETS) ? MIN_BUCKETS :
		(bc_q > BC_W'(MAX_BUCKETS)) ? BC_W'(MAX_BUCKETS) : bc_q;
	assign trial = {rem_q[31:0], h_q[31]} - {20'd0, div_q};

	assign pready = 1'b1;
	assign prdata = (paddr == 2'(REG_NBUCKETS * 4)) ? {19'd0, bc_q} : 32'd0;
	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.status = st_q;
	assign out_ch.found_record = fr_q;

	always_comb begin
		h_we = 1'b0;
		h_waddr = rem_q[BKT_AW-1:0];
		h_wdata = {1'b1, used_q[NODE_AW-1:0]};
		h_raddr = rem_q[BKT_AW-1:0];
		n_we = 1'b0;
		n_raddr = cur_q;
		n_wdata = '{key: key_q, rec: rec_q, link: h_rdata[NODE_AW-1:0],
			has_next: h_rdata[NODE_AW]};
		if (state_q == S_CLR) begin
			h_we = 1'b1;
			h_waddr = clr_q;
			h_wdata = '0;
		end
		if (state_q == S_INS) begin
			h_we = 1'b1;
			n_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			bc_q <= BC_RESET;
			clr_q <= '0;
			used_q <= '0;
		end else begin
			if (psel && penable && pwrite && paddr == 2'(REG_NBUCKETS * 4))
				bc_q <= pwdata[BC_W-1:0];
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BKT_AW'(MAX_BUCKETS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (in_ch.valid) state_q <= S_M1;
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_DIV;
				S_DIV: if (dcnt_q == 6'd31) state_q <= S_HRD;
				S_HRD: state_q <= S_HWT;
				S_HWT: begin
					if (mode_q == MODE_INSERT)
						state_q <= (used_q >= CNT_W'(POOL_NODES)) ? S_OUT : S_INS;
					else if (h_rdata[NODE_AW] &&
						{1'b0, h_rdata[NODE_AW-1:0]} < used_q)
						state_q <= S_NRD;
					else state_q <= S_OUT;
				end
				S_INS: begin
					used_q <= used_q + 1'b1;
					state_q <= S_OUT;
				end
				S_NRD: state_q <= S_NWT;
				S_NWT: begin
					if (n_rdata.key == key_q) state_q <= S_OUT;
					else if (n_rdata.has_next && {1'b0, n_rdata.link} < used_q &&
						steps_q < (NODE_AW+1)'(POOL_NODES - 1))
						state_q <= S_NRD;
					else state_q <= S_OUT;
				end
				S_OUT: if (out_ch.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mode_q <= in_ch.mode;
				key_q <= in_ch.code_point;
				rec_q <= in_ch.record[RECORD_BITS-1:0];
				h_q <= {11'd0, in_ch.code_point};
			end
			S_M1: h_q <= prod;
			S_M2: begin
				h_q <= prod ^ (prod >> HASH_SHIFT);
				rem_q <= '0;
				div_q <= bc_eff;
				dcnt_q <= '0;
			end
			S_DIV: begin
				h_q <= {h_q[30:0], 1'b0};
				dcnt_q <= dcnt_q + 1'b1;
				rem_q <= trial[32] ? {rem_q[30:0], h_q[31]} : trial[31:0];
			end
			S_HWT: begin
				cur_q <= h_rdata[NODE_AW-1:0];
				steps_q <= '0;
				fr_q <= '0;
				if (mode_q == MODE_INSERT)
					st_q <= (used_q >= CNT_W'(POOL_NODES)) ? ST_FULL : ST_OK;
				else st_q <= ST_MISS;
			end
			S_NWT: begin
				cur_q <= n_rdata.link;
				steps_q <= steps_q + 1'b1;
				if (n_rdata.key == key_q) begin
					st_q <= ST_OK;
					fr_q <= REC_W'(n_rdata.rec);
				end
			end
			default: ;
		endcase
	end

	a_one_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("accepted twice");
	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(POOL_NODES))
		else $error("pool overrun");
	a_ins_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS) |=> (state_q == S_OUT && st_q == ST_OK))
		else $error("insert status");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && st_q != ST_OK) |-> fr_q == '0)
		else $error("record on miss");
endmodule
`default_nettype wire

FILE: verif/tb_chained_hash_key_index.sv
`timescale 1ns / 1ps
module tb_chained_hash_key_index;
	import chki_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 64;
	localparam logic [20:0] CP_MAX = 21'd1114111;

	typedef struct {
		logic [ST_W-1:0] status;
		logic [REC_W-1:0] found_record;
	} reply_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	chki_in_if in_ch ();
	chki_out_if out_ch ();

	chained_hash_key_index i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	// index model state
	logic [BC_W-1:0] bucket_cfg;
	logic [NODE_AW-1:0] head_of[MAX_BUCKETS];
	logic head_live[MAX_BUCKETS];
	logic [KEY_W-1:0] key_of[POOL_NODES];
	logic [REC_W-1:0] rec_of[POOL_NODES];
	logic [NODE_AW-1:0] link_of[POOL_NODES];
	logic link_live[POOL_NODES];
	int nodes_taken;

	reply_t pending_replies[$];
	logic [KEY_W-1:0] known_keys[$];
	int errors;
	int cycles;
	int in_idle_pct;
	int out_idle_pct;
	int n_inserts, n_hits, n_misses, n_full;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("chained_hash_key_index test failed");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
		end
	end

	function automatic logic [31:0] mix_key(logic [31:0] k);
		logic [31:0] h;
		h = k;
		h = ((h >> HASH_SHIFT) ^ h) * HASH_MUL;
		h = ((h >> HASH_SHIFT) ^ h) * HASH_MUL;
		return (h >> HASH_SHIFT) ^ h;
	endfunction

	function automatic reply_t index_predict(logic mode, logic [KEY_W-1:0] cp,
			logic [REC_W-1:0] rec);
		reply_t r;
		int n;
		int b;
		int cur;
		logic live;
		n = bucket_cfg;
		if (n < MIN_BUCKETS) n = MIN_BUCKETS;
		if (n > MAX_BUCKETS) n = MAX_BUCKETS;
		b = mix_key({11'd0, cp}) % n;
		r.status = ST_OK;
		r.found_record = '0;
		if (mode == MODE_INSERT) begin
			if (nodes_taken >= POOL_NODES) begin
				r.status = ST_FULL;
				n_full++;
				return r;
			end
			key_of[nodes_taken] = cp;
			rec_of[nodes_taken] = rec;
			link_of[nodes_taken] = head_of[b];
			link_live[nodes_taken] = head_live[b];
			head_of[b] = NODE_AW'(nodes_taken);
			head_live[b] = 1'b1;
			nodes_taken++;
			n_inserts++;
			return r;
		end
		live = head_live[b];
		cur = head_of[b];
		while (live && cur < nodes_taken) begin
			if (key_of[cur] == cp) begin
				r.found_record = rec_of[cur];
				n_hits++;
				return r;
			end
			live = link_live[cur];
			cur = link_of[cur];
		end
		r.status = ST_MISS;
		n_misses++;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h, expected %h", what, got, want);
		errors++;
	endtask

	always @(negedge clk) begin
		reply_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_replies.size() == 0) begin
				report_mismatch("unexpected word", 64'(out_ch.status), 64'd0);
			end else begin
				want = pending_replies.pop_front();
				if (out_ch.status !== want.status)
					report_mismatch("status", 64'(out_ch.status), 64'(want.status));
				if (out_ch.found_record !== want.found_record)
					report_mismatch("found_record", out_ch.found_record, want.found_record);
			end
		end
	end

	task automatic send_word(logic mode, logic [KEY_W-1:0] cp, logic [REC_W-1:0] rec);
		int gap;
		gap = 0;
		if ($urandom_range(99) < in_idle_pct) gap = $urandom_range(6, 1);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= mode;
		in_ch.code_point <= cp;
		in_ch.record <= rec;
		do @(negedge clk); while (!in_ch.ready);
		@(posedge clk);
		pending_replies.push_back(index_predict(mode, cp, rec));
		if (mode == MODE_INSERT) known_keys.push_back(cp);
	endtask

	task automatic wait_drained();
		if (in_ch.valid) in_ch.valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_nbuckets(logic [BC_W-1:0] value);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 2'(REG_NBUCKETS * 4);
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		bucket_cfg = value;
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		if (known_keys.size() != 0 && $urandom_range(99) < 70)
			return known_keys[$urandom_range(known_keys.size() - 1)];
		return KEY_W'($urandom_range(CP_MAX));
	endfunction

	function automatic logic [REC_W-1:0] any_record();
		return {$urandom(), $urandom()};
	endfunction

	task automatic test_directed();
		in_idle_pct = 0;
		out_idle_pct = 0;
		send_word(MODE_FIND, 21'd0, '0);
		send_word(MODE_INSERT, 21'd0, '0);
		send_word(MODE_INSERT, CP_MAX, '1);
		send_word(MODE_FIND, 21'd0, '1);
		send_word(MODE_FIND, CP_MAX, '0);
		send_word(MODE_INSERT, 21'h0abcde, 64'h0123456789abcdef);
		send_word(MODE_INSERT, 21'h0abcde, 64'hfedcba9876543210);
		send_word(MODE_FIND, 21'h0abcde, '0);
		send_word(MODE_FIND, 21'h155555, '0);
		send_word(MODE_INSERT, 21'h155555, 64'h5555aaaa5555aaaa);
		// below the minimum, used as 64
		write_nbuckets('0);
		send_word(MODE_FIND, 21'h155555, '0);
		// above the maximum, clamped
		write_nbuckets('1);
		send_word(MODE_FIND, 21'h155555, '0);
		send_word(MODE_FIND, 21'h0abcde, '0);
		send_word(MODE_INSERT, 21'h155555, 64'h1);
		send_word(MODE_FIND, 21'h155555, '0);
		write_nbuckets(13'd4096);
		send_word(MODE_FIND, 21'h155555, '0);
		write_nbuckets(13'd64);
		send_word(MODE_FIND, 21'h155555, '0);
		send_word(MODE_FIND, CP_MAX, '0);
		write_nbuckets(13'd100);
		send_word(MODE_FIND, 21'h0abcde, '0);
	endtask

	task automatic test_random(int count, int in_pct, int out_pct, logic [BC_W-1:0] bc);
		logic [KEY_W-1:0] k;
		write_nbuckets(bc);
		in_idle_pct = in_pct;
		out_idle_pct = out_pct;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2) wait_drained();
			k = pick_key();
			send_word(($urandom_range(99) < 40) ? MODE_INSERT : MODE_FIND, k,
				any_record());
		end
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		nodes_taken = 0;
		n_inserts = 0;
		n_hits = 0;
		n_misses = 0;
		n_full = 0;
		in_idle_pct = 0;
		out_idle_pct = 0;
		bucket_cfg = BC_RESET;
		for (int i = 0; i < MAX_BUCKETS; i++) begin
			head_of[i] = '0;
			head_live[i] = 1'b0;
		end
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_FIND;
		in_ch.code_point = '0;
		in_ch.record = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(600, 38, 45, 13'd64);
		test_random(600, 45, 38, 13'($urandom_range(4096, 65)));
		test_random(550, 0, 0, 13'd4096);
		wait_drained();
		$display("inserts %0d, finds hit %0d, missed %0d, pool full %0d", n_inserts,
			n_hits, n_misses, n_full);
		$display("bucket counts 0, 64, 100, 4096, 8191 and random; mismatches %0d", errors);
		if (errors == 0) begin
			$display("chained_hash_key_index test passed");
		end else begin
			$display("chained_hash_key_index test failed");
		end
		$finish;
	end
endmodule

FILE: chained_hash_key_index.f
rtl/core/chki_pkg.sv
rtl/core/chki_if.sv
rtl/core/chki_ram.sv
rtl/core/chained_hash_key_index.sv
verif/tb_chained_hash_key_index.sv
